// File: rtl/dvrt_pkg.sv
package dvrt_pkg;

  localparam int unsigned ID_W   = 16;
  localparam int unsigned COST_W = 16;
  localparam int unsigned TIME_W = 32;

  // Opcodes carried in the input tuser.
  localparam logic [2:0] OP_PONG   = 3'd0;
  localparam logic [2:0] OP_VEC    = 3'd1;
  localparam logic [2:0] OP_END    = 3'd2;
  localparam logic [2:0] OP_EXPIRE = 3'd3;
  localparam logic [2:0] OP_DROP   = 3'd4;
  localparam logic [2:0] OP_EXPORT = 3'd5;

  // Configuration register indexes.
  localparam logic [1:0] REG_SELF_ID  = 2'd0;
  localparam logic [1:0] REG_INF_COST = 2'd1;
  localparam logic [1:0] REG_TIMEOUT  = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]   dest;
    logic [COST_W-1:0] cost;
    logic [ID_W-1:0]   hop;
    logic [TIME_W-1:0] expiry;
  } entry_t;

  typedef struct packed {
    logic   en;
    entry_t ent;
  } wr_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_EV,
    ST_CALC,
    ST_APPLY,
    ST_EMIT
  } state_t;

endpackage

// File: rtl/dvrt_table.sv
module dvrt_table #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  dvrt_pkg::wr_t            wr,
  input  logic [$clog2(DEPTH)-1:0] wr_idx,
  input  logic [$clog2(DEPTH)-1:0] rd_idx,
  output dvrt_pkg::entry_t         rd_ent
);

  dvrt_pkg::entry_t mem [DEPTH];
  dvrt_pkg::entry_t rd_ent_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_idx] <= wr.ent;
    end
    rd_ent_r <= mem[rd_idx];
  end

  assign rd_ent = rd_ent_r;

endmodule

// File: rtl/distance_vector_route_table.sv
// Each item walks the whole table slot by slot, reading each slot and then evaluating it;
// pong and vector entries then compute a cost and update the table. A vector entry naming
// this router or an unused opcode skips the walk. One item at a time; export may stall
// mid-walk while the result side is not ready. Reset clears the valid and seen bits, the
// pending change flag and the output valid, and sets the configuration defaults.
module distance_vector_route_table #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [87:0] in_tdata,  // neighbor_id, dest_id, cost_in, now, zero fill
  input  logic [2:0]  in_tuser,  // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata, // changed, dest_out, cost_out, zero fill
  output logic        out_tuser, // entry_valid
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  dvrt_pkg::state_t state_r, state_nxt;

  logic [15:0] self_id_r, inf_r;
  logic [31:0] tmo_r;

  logic [TABLE_DEPTH-1:0] vld_r, vld_nxt, seen_r, seen_nxt;
  logic pend_chg_r, pend_chg_nxt;

  logic [2:0]  op_r, op_nxt;
  logic [15:0] nb_r, nb_nxt, dst_r, dst_nxt, cin_r, cin_nxt;
  logic [31:0] now_r, now_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic chg_r, chg_nxt;

  logic n_hit_r, n_hit_nxt;
  logic [15:0] n_cost_r, n_cost_nxt;
  logic s_hit_r, s_hit_nxt;
  logic [IDX_W-1:0] s_idx_r, s_idx_nxt;
  dvrt_pkg::entry_t s_ent_r, s_ent_nxt;
  logic f_hit_r, f_hit_nxt;
  logic [IDX_W-1:0] f_idx_r, f_idx_nxt;

  logic [15:0] newc_r, newc_nxt;
  logic [31:0] exp_r, exp_nxt;

  logic px_hit_r, px_hit_nxt;
  logic [15:0] px_dest_r, px_dest_nxt, px_cost_r, px_cost_nxt;

  logic out_valid_r, out_valid_nxt;
  logic out_chg_r, out_chg_nxt, out_ev_r, out_ev_nxt, out_last_r, out_last_nxt;
  logic [15:0] out_dest_r, out_dest_nxt, out_cost_r, out_cost_nxt;

  dvrt_pkg::wr_t wr;
  logic [IDX_W-1:0] wr_idx;
  dvrt_pkg::entry_t rd;

  logic out_free;
  logic [16:0] sum;
  logic [15:0] key;
  dvrt_pkg::entry_t upd;

  dvrt_table #(.DEPTH(TABLE_DEPTH)) u_table (
    .clk    (clk),
    .wr     (wr),
    .wr_idx (wr_idx),
    .rd_idx (idx_r),
    .rd_ent (rd)
  );

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == dvrt_pkg::ST_IDLE);
  assign out_free  = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      self_id_r <= 16'd0;
      inf_r     <= 16'hFFFF;
      tmo_r     <= 32'd1000;
    end else if (cfg_valid) begin
      case (cfg_index)
        dvrt_pkg::REG_SELF_ID:  self_id_r <= cfg_data[15:0];
        dvrt_pkg::REG_INF_COST: inf_r     <= cfg_data[15:0];
        dvrt_pkg::REG_TIMEOUT:  tmo_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dvrt_pkg::ST_IDLE;
      vld_r       <= '0;
      seen_r      <= '0;
      pend_chg_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vld_r       <= vld_nxt;
      seen_r      <= seen_nxt;
      pend_chg_r  <= pend_chg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;       nb_r <= nb_nxt;         dst_r <= dst_nxt;
    cin_r <= cin_nxt;     now_r <= now_nxt;       idx_r <= idx_nxt;
    chg_r <= chg_nxt;     n_hit_r <= n_hit_nxt;   n_cost_r <= n_cost_nxt;
    s_hit_r <= s_hit_nxt; s_idx_r <= s_idx_nxt;   s_ent_r <= s_ent_nxt;
    f_hit_r <= f_hit_nxt; f_idx_r <= f_idx_nxt;   newc_r <= newc_nxt;
    exp_r <= exp_nxt;     px_hit_r <= px_hit_nxt; px_dest_r <= px_dest_nxt;
    px_cost_r <= px_cost_nxt;
    out_chg_r <= out_chg_nxt;   out_ev_r <= out_ev_nxt;     out_last_r <= out_last_nxt;
    out_dest_r <= out_dest_nxt; out_cost_r <= out_cost_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    vld_nxt = vld_r;         seen_nxt = seen_r;       pend_chg_nxt = pend_chg_r;
    op_nxt = op_r;           nb_nxt = nb_r;           dst_nxt = dst_r;
    cin_nxt = cin_r;         now_nxt = now_r;         idx_nxt = idx_r;
    chg_nxt = chg_r;         n_hit_nxt = n_hit_r;     n_cost_nxt = n_cost_r;
    s_hit_nxt = s_hit_r;     s_idx_nxt = s_idx_r;     s_ent_nxt = s_ent_r;
    f_hit_nxt = f_hit_r;     f_idx_nxt = f_idx_r;     newc_nxt = newc_r;
    exp_nxt = exp_r;         px_hit_nxt = px_hit_r;   px_dest_nxt = px_dest_r;
    px_cost_nxt = px_cost_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_chg_nxt = out_chg_r;   out_ev_nxt = out_ev_r;     out_last_nxt = out_last_r;
    out_dest_nxt = out_dest_r; out_cost_nxt = out_cost_r;
    wr = '0;
    wr_idx = s_idx_r;
    sum = 17'(cin_r) + 17'(n_cost_r);
    key = (op_r == dvrt_pkg::OP_PONG) ? nb_r : dst_r;
    upd = s_ent_r;

    case (state_r)
      dvrt_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          op_nxt  = in_tuser;
          nb_nxt  = in_tdata[15:0];
          dst_nxt = in_tdata[31:16];
          cin_nxt = in_tdata[47:32];
          now_nxt = in_tdata[79:48];
          idx_nxt = '0;
          chg_nxt = 1'b0;
          n_hit_nxt = 1'b0; s_hit_nxt = 1'b0; f_hit_nxt = 1'b0; px_hit_nxt = 1'b0;
          if (in_tuser > dvrt_pkg::OP_EXPORT ||
              (in_tuser == dvrt_pkg::OP_VEC && in_tdata[31:16] == self_id_r)) begin
            state_nxt = dvrt_pkg::ST_EMIT;
          end else begin
            state_nxt = dvrt_pkg::ST_RD;
          end
        end
      end
      dvrt_pkg::ST_RD: begin
        state_nxt = dvrt_pkg::ST_EV;
      end
      dvrt_pkg::ST_EV: begin
        if (!(op_r == dvrt_pkg::OP_EXPORT && vld_r[idx_r] && px_hit_r && !out_free)) begin
          case (op_r)
            dvrt_pkg::OP_PONG, dvrt_pkg::OP_VEC: begin
              if (vld_r[idx_r] && rd.dest == nb_r && !n_hit_r) begin
                n_hit_nxt = 1'b1;
                n_cost_nxt = rd.cost;
              end
              if (vld_r[idx_r] && rd.dest == key && !s_hit_r) begin
                s_hit_nxt = 1'b1;
                s_idx_nxt = idx_r;
                s_ent_nxt = rd;
              end
              if (!vld_r[idx_r] && !f_hit_r) begin
                f_hit_nxt = 1'b1;
                f_idx_nxt = idx_r;
              end
            end
            dvrt_pkg::OP_END: begin
              if (vld_r[idx_r] && rd.dest != nb_r && rd.hop == nb_r && !seen_r[idx_r]) begin
                vld_nxt[idx_r]  = 1'b0;
                seen_nxt[idx_r] = 1'b0;
                chg_nxt = 1'b1;
              end
            end
            dvrt_pkg::OP_EXPIRE: begin
              if (vld_r[idx_r] && rd.expiry < now_r) begin
                vld_nxt[idx_r]  = 1'b0;
                seen_nxt[idx_r] = 1'b0;
                chg_nxt = 1'b1;
              end
            end
            dvrt_pkg::OP_DROP: begin
              if (vld_r[idx_r] && rd.hop == nb_r) begin
                vld_nxt[idx_r]  = 1'b0;
                seen_nxt[idx_r] = 1'b0;
                chg_nxt = 1'b1;
              end
            end
            default: begin
              // Export holds one entry back so that the final beat can carry tlast.
              if (vld_r[idx_r]) begin
                if (px_hit_r) begin
                  out_valid_nxt = 1'b1;
                  out_chg_nxt = 1'b0;
                  out_ev_nxt = 1'b1;
                  out_last_nxt = 1'b0;
                  out_dest_nxt = px_dest_r;
                  out_cost_nxt = px_cost_r;
                end
                px_hit_nxt = 1'b1;
                px_dest_nxt = rd.dest;
                px_cost_nxt = (rd.hop == nb_r) ? inf_r : rd.cost;
              end
            end
          endcase
          if (idx_r == LAST_IDX) begin
            if (op_r == dvrt_pkg::OP_PONG || op_r == dvrt_pkg::OP_VEC) begin
              state_nxt = dvrt_pkg::ST_CALC;
            end else begin
              if (op_r == dvrt_pkg::OP_END) begin
                seen_nxt = '0;
                chg_nxt = chg_nxt || pend_chg_r;
                pend_chg_nxt = 1'b0;
              end
              state_nxt = dvrt_pkg::ST_EMIT;
            end
          end else begin
            idx_nxt = idx_r + 1'b1;
            state_nxt = dvrt_pkg::ST_RD;
          end
        end
      end
      dvrt_pkg::ST_CALC: begin
        exp_nxt = now_r + tmo_r;
        if (op_r == dvrt_pkg::OP_PONG) begin
          newc_nxt = (cin_r > inf_r) ? inf_r : cin_r;
        end else if (s_hit_r && cin_r == inf_r) begin
          newc_nxt = inf_r;
        end else begin
          newc_nxt = (sum > 17'(inf_r)) ? inf_r : sum[15:0];
        end
        state_nxt = dvrt_pkg::ST_APPLY;
      end
      dvrt_pkg::ST_APPLY: begin
        upd.expiry = exp_r;
        if (op_r == dvrt_pkg::OP_PONG) begin
          if (s_hit_r) begin
            wr.en = 1'b1;
            if (newc_r != s_ent_r.cost) begin
              if (s_ent_r.hop == nb_r) begin
                upd.cost = newc_r;
                chg_nxt = 1'b1;
              end else if (newc_r < s_ent_r.cost) begin
                upd.cost = newc_r;
                upd.hop = nb_r;
                chg_nxt = 1'b1;
              end
            end
          end else if (f_hit_r) begin
            wr.en = 1'b1;
            wr_idx = f_idx_r;
            upd = '{dest: nb_r, cost: newc_r, hop: nb_r, expiry: exp_r};
            vld_nxt[f_idx_r] = 1'b1;
            seen_nxt[f_idx_r] = 1'b0;
            chg_nxt = 1'b1;
          end
        end else begin
          if (s_hit_r) begin
            seen_nxt[s_idx_r] = 1'b1;
            if (n_hit_r) begin
              wr.en = 1'b1;
              if (newc_r < s_ent_r.cost) begin
                upd.cost = newc_r;
                upd.hop = nb_r;
                chg_nxt = 1'b1;
              end
            end
          end else if (n_hit_r && f_hit_r) begin
            wr.en = 1'b1;
            wr_idx = f_idx_r;
            upd = '{dest: dst_r, cost: newc_r, hop: nb_r, expiry: exp_r};
            vld_nxt[f_idx_r] = 1'b1;
            seen_nxt[f_idx_r] = 1'b1;
            chg_nxt = 1'b1;
          end
          pend_chg_nxt = pend_chg_r || chg_nxt;
        end
        wr.ent = upd;
        state_nxt = dvrt_pkg::ST_EMIT;
      end
      dvrt_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_last_nxt = 1'b1;
          out_chg_nxt = chg_r;
          out_ev_nxt = 1'b0;
          out_dest_nxt = 16'd0;
          out_cost_nxt = 16'd0;
          if (op_r == dvrt_pkg::OP_EXPORT && px_hit_r) begin
            out_ev_nxt = 1'b1;
            out_dest_nxt = px_dest_r;
            out_cost_nxt = px_cost_r;
          end
          state_nxt = dvrt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dvrt_pkg::ST_IDLE;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_cost_r, out_dest_r, out_chg_r};
  assign out_tuser  = out_ev_r;
  assign out_tlast  = out_last_r;

  // A seen mark only ever sits on a slot that holds a route.
  a_seen_on_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (seen_r & ~vld_r) == '0)
    else $error("seen bit set on an empty slot");

  // Only a vector entry raises the packet's pending change flag.
  a_pend_from_vec: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_chg_r && !$past(pend_chg_r)) |-> $past(op_r) == dvrt_pkg::OP_VEC)
    else $error("pending change raised outside a vector entry");

  // The table is written only in the update step, which hands over to the result.
  a_apply_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> (state_r == dvrt_pkg::ST_APPLY) ##1 (state_r == dvrt_pkg::ST_EMIT))
    else $error("table written outside the update step");

endmodule
